FILE: rtl/core/f2u8_pkg.sv
// Shared types for the float-to-byte quantizer.
// Depends on nothing; used by f2u8_round and float_to_uint8_scale_bias.
`timescale 1ns / 1ps
`default_nettype none

package f2u8_pkg;

    localparam int MANT_W = 49;
    localparam int EXP_W  = 11;

    localparam logic [0:0] REG_SCALE  = 1'b0;
    localparam logic [0:0] REG_OFFSET = 1'b1;

    localparam logic [31:0] SCALE_RESET  = 32'h3F80_0000;
    localparam logic [31:0] OFFSET_RESET = 32'h0000_0000;
    localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        SP_FIN,
        SP_INF,
        SP_NAN
    } spec_t;

    // Exact value is mant * 2^expo, to be rounded to single precision.
    typedef struct packed {
        logic                    sign;
        spec_t                   spec;
        logic [MANT_W-1:0]       mant;
        logic signed [EXP_W-1:0] expo;
    } rnd_in_t;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        row_end_in;
        logic        frame_end_in;
    } in_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       row_end_out;
        logic       frame_end_out;
    } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/f2u8_round.sv
// Two-stage normalize and round-to-nearest-even packer for single precision.
// Depends on f2u8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module f2u8_round
    import f2u8_pkg::*;
(
    input  wire logic        clk,
    input  wire rnd_in_t     op,
    output logic [31:0]      bits
);

    logic [MANT_W-1:0]       norm_reg, norm_next;
    logic signed [EXP_W-1:0] expo_reg, expo_next;
    logic                    sign_reg;
    spec_t                   spec_reg;
    logic                    zero_reg;
    logic [31:0]             bits_reg, bits_next;
    logic [5:0]              lz;

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < MANT_W; i++)
        begin
            if (op.mant[i])
            begin
                lz = 6'(MANT_W - 1 - i);
            end
        end
        norm_next = op.mant << lz;
        expo_next = op.expo + 11'sd175 - $signed({5'b0, lz});
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        expo_reg <= expo_next;
        sign_reg <= op.sign;
        spec_reg <= op.spec;
        zero_reg <= (op.mant == '0);
    end

    logic signed [EXP_W-1:0] dd;
    logic [5:0]              d;
    logic [MANT_W-1:0]       shifted;
    logic                    lost;
    logic [23:0]             top;
    logic                    up;
    logic [24:0]             mr;
    logic [7:0]              eeff;
    logic [31:0]             packed_bits;

    always_comb
    begin
        dd = 11'sd1 - expo_reg;
        if (expo_reg < 11'sd1)
        begin
            d    = (dd > 11'sd63) ? 6'd63 : dd[5:0];
            eeff = 8'd1;
        end
        else
        begin
            d    = 6'd0;
            eeff = expo_reg[7:0];
        end
        shifted     = norm_reg >> d;
        lost        = |(norm_reg & ~({MANT_W{1'b1}} << d));
        top         = shifted[48:25];
        up          = shifted[24] & ((|shifted[23:0]) | lost | top[0]);
        mr          = {1'b0, top} + 25'(up);
        packed_bits = {1'b0, eeff - 8'd1, 23'b0} + {7'b0, mr};
        case (spec_reg)
            SP_NAN: bits_next = QNAN_BITS;
            SP_INF: bits_next = {sign_reg, 8'hFF, 23'b0};
            default:
            begin
                if (zero_reg)
                    bits_next = {sign_reg, 31'b0};
                else if (expo_reg >= 11'sd255)
                    bits_next = {sign_reg, 8'hFF, 23'b0};
                else
                    bits_next = {sign_reg, packed_bits[30:0]};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign bits = bits_reg;

endmodule

`default_nettype wire

FILE: rtl/core/float_to_uint8_scale_bias.sv
// Top level: byte = sat255(trunc(max(x*scale+offset, 0) + 0.5)) in single precision.
// Depends on f2u8_pkg and f2u8_round.
//
//   Port group   Dir  Handshake            Payload
//   sample       in   start, busy          in_t
//   result       out  done (strobe)        out_t
//   cfg          in   cfg_valid, cfg_ready cfg_index, cfg_data
//
// Every beat passes these registered stages from start to done: multiply, two
// rounding stages, align and add, two rounding stages, quantize.
// A new beat is taken every cycle; busy stays low.
// Reset clears the valid pipeline and restores scale 1.0 and offset +0.0.
// The receiver cannot stall; results leave on done.
`timescale 1ns / 1ps
`default_nettype none

module float_to_uint8_scale_bias
    import f2u8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_t         sample,
    output logic             done,
    output out_t             result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] scale_reg, scale_next;
    logic [31:0] offset_reg, offset_next;
    logic [6:0]  vld_reg, vld_next;
    logic [6:0]  row_reg, row_next;
    logic [6:0]  frame_reg, frame_next;
    logic        accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_comb
    begin
        scale_next  = scale_reg;
        offset_next = offset_reg;
        if (cfg_valid & cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE:  scale_next  = cfg_data;
                REG_OFFSET: offset_next = cfg_data;
                default:    scale_next  = scale_reg;
            endcase
        end
        vld_next   = {vld_reg[5:0], accept};
        row_next   = {row_reg[5:0], sample.row_end_in};
        frame_next = {frame_reg[5:0], sample.frame_end_in};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RESET;
            offset_reg <= OFFSET_RESET;
            vld_reg    <= '0;
        end
        else
        begin
            scale_reg  <= scale_next;
            offset_reg <= offset_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        frame_reg <= frame_next;
    end

    // Multiply stage.
    logic [31:0] xa, xb;
    logic [7:0]  mea, meb, mEa, mEb;
    logic [23:0] mma, mmb;
    logic [47:0] mprod;
    logic        mnan_a, mnan_b, minf_a, minf_b, mzero_a, mzero_b;
    rnd_in_t     mul_next, mul_reg;

    always_comb
    begin
        xa      = sample.sample_bits;
        xb      = scale_reg;
        mea     = xa[30:23];
        meb     = xb[30:23];
        mma     = {mea != 8'd0, xa[22:0]};
        mmb     = {meb != 8'd0, xb[22:0]};
        mEa     = (mea == 8'd0) ? 8'd1 : mea;
        mEb     = (meb == 8'd0) ? 8'd1 : meb;
        mnan_a  = (mea == 8'hFF) && (xa[22:0] != 23'd0);
        mnan_b  = (meb == 8'hFF) && (xb[22:0] != 23'd0);
        minf_a  = (mea == 8'hFF) && (xa[22:0] == 23'd0);
        minf_b  = (meb == 8'hFF) && (xb[22:0] == 23'd0);
        mzero_a = (xa[30:0] == 31'd0);
        mzero_b = (xb[30:0] == 31'd0);
        mprod   = mma * mmb;
        mul_next.sign = xa[31] ^ xb[31];
        mul_next.mant = {1'b0, mprod};
        mul_next.expo = $signed({2'b0, {1'b0, mEa} + {1'b0, mEb}}) - 11'sd300;
        if (mnan_a | mnan_b | (minf_a & mzero_b) | (mzero_a & minf_b))
            mul_next.spec = SP_NAN;
        else if (minf_a | minf_b)
            mul_next.spec = SP_INF;
        else
            mul_next.spec = SP_FIN;
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_next;
    end

    logic [31:0] prod_bits;

    f2u8_round u_round_mul (
        .clk  (clk),
        .op   (mul_reg),
        .bits (prod_bits)
    );

    // Align and add stage.
    logic [31:0] big, sml;
    logic [7:0]  aEB, aES, adiff;
    logic [23:0] amB, amS;
    logic [47:0] afull, bfull, bsh;
    logic        alost, asub;
    logic [48:0] asum;
    logic        anan_a, anan_b, ainf_a, ainf_b;
    rnd_in_t     add_next, add_reg;

    always_comb
    begin
        if (prod_bits[30:0] >= offset_reg[30:0])
        begin
            big = prod_bits;
            sml = offset_reg;
        end
        else
        begin
            big = offset_reg;
            sml = prod_bits;
        end
        aEB    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        aES    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        amB    = {big[30:23] != 8'd0, big[22:0]};
        amS    = {sml[30:23] != 8'd0, sml[22:0]};
        adiff  = aEB - aES;
        afull  = {amB, 24'b0};
        bfull  = {amS, 24'b0};
        bsh    = bfull >> adiff;
        alost  = |(bfull & ~({48{1'b1}} << adiff));
        bsh    = bsh | {47'b0, alost};
        asub   = prod_bits[31] ^ offset_reg[31];
        asum   = asub ? ({1'b0, afull} - {1'b0, bsh}) : ({1'b0, afull} + {1'b0, bsh});
        anan_a = (prod_bits[30:23] == 8'hFF) && (prod_bits[22:0] != 23'd0);
        anan_b = (offset_reg[30:23] == 8'hFF) && (offset_reg[22:0] != 23'd0);
        ainf_a = (prod_bits[30:23] == 8'hFF) && (prod_bits[22:0] == 23'd0);
        ainf_b = (offset_reg[30:23] == 8'hFF) && (offset_reg[22:0] == 23'd0);
        add_next.mant = asum;
        add_next.expo = $signed({3'b0, aEB}) - 11'sd174;
        add_next.sign = (asum == 49'd0) ? (prod_bits[31] & offset_reg[31]) : big[31];
        add_next.spec = SP_FIN;
        if (anan_a | anan_b | (ainf_a & ainf_b & asub))
        begin
            add_next.spec = SP_NAN;
        end
        else if (ainf_a | ainf_b)
        begin
            add_next.spec = SP_INF;
            add_next.sign = ainf_a ? prod_bits[31] : offset_reg[31];
        end
    end

    always_ff @(posedge clk)
    begin
        add_reg <= add_next;
    end

    logic [31:0] sum_bits;

    f2u8_round u_round_add (
        .clk  (clk),
        .op   (add_reg),
        .bits (sum_bits)
    );

    // Quantize stage: round half up of a positive value, with the one
    // value just below one half that rounds up to one in single precision.
    logic [7:0]  qe;
    logic [4:0]  qsh;
    logic [23:0] qsig;
    logic [8:0]  qq;
    logic [9:0]  qr;
    logic [7:0]  pix_reg, pix_next;

    always_comb
    begin
        qe   = sum_bits[30:23];
        qsig = {1'b1, sum_bits[22:0]};
        qsh  = 5'(8'd149 - qe);
        qq   = 9'(qsig >> qsh);
        qr   = {1'b0, qq} + 10'd1;
        if (sum_bits[31] || (sum_bits[30:0] == 31'd0))
            pix_next = 8'd0;
        else if (qe == 8'hFF)
            pix_next = (sum_bits[22:0] == 23'd0) ? 8'd255 : 8'd0;
        else if (sum_bits == 32'h3EFF_FFFF)
            pix_next = 8'd1;
        else if (qe < 8'd126)
            pix_next = 8'd0;
        else if (qe >= 8'd135)
            pix_next = 8'd255;
        else
            pix_next = qr[9] ? 8'd255 : qr[8:1];
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    assign done                 = vld_reg[6];
    assign result.pixel_byte    = pix_reg;
    assign result.row_end_out   = row_reg[6];
    assign result.frame_end_out = frame_reg[6];

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("accepted beat did not complete after seven cycles");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result strobe without an accepted beat");

    a_row_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.row_end_out == $past(sample.row_end_in, 7)))
        else $error("row end flag not carried with its beat");

    a_negative_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[5] && sum_bits[31]) |=> (result.pixel_byte == 8'd0))
        else $error("negative sum did not clamp to zero");
`endif

endmodule

`default_nettype wire
